// ===== hdl/rc4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the RC4 keystream cipher.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int KLEN_W     = 9;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [1:0]        mode_t;
    typedef logic [KLEN_W-1:0] klen_t;

    localparam mode_t MODE_KEY   = 2'd0;
    localparam mode_t MODE_SETUP = 2'd1;
    localparam mode_t MODE_CRYPT = 2'd2;

    localparam klen_t KLEN_RESET = 9'd16;
    localparam byte_t PERM_LAST  = 8'(PERM_DEPTH - 1);

endpackage : rc4_pkg
`default_nettype wire

// ===== hdl/rc4_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : rc4_ram
`default_nettype wire

// ===== hdl/rc4_keystream_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_keystream_cipher
// RC4 engine: key store, key schedule and byte-wise encrypt/decrypt.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry mode, key_index and value. A key beat (mode 0) writes
//   one key byte and completes in its accept cycle with no result. A setup
//   beat (mode 1) runs the key schedule and returns one beat with is_ack set
//   and out_byte zero. A crypt beat (mode 2) returns value XOR keystream.
//   Mode 3 is dropped.
//   Crypt: accept, then three dependent reads/writes (CA, CB, CC) on the
//   single 1R1W permutation RAM. Setup: fill all 256 entries, then one swap
//   step (KRD, KACC, KW1, KW2) for each of the 256 entries, then the ack.
//   in_stall is high while a beat is being worked on, and also while a
//   finished result cannot enter the output register.
//   The output register holds its beat while out_stall is high; the block
//   accepts the next input as soon as the result sits in that register.
//   cfg_data sets key_length; writes are taken at any time (ready is tied
//   high) and belong to idle periods.
//   Reset clears pointers, control state and key_length (16). Key store and
//   permutation contents are undefined until loaded and set up.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  key_index,
    input  wire logic [7:0]  value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             is_ack
);

    localparam int    KW       = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam klen_t KLEN_MAX = KLEN_W'(MAX_KEY_BYTES);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FILL = 4'd1;
    localparam logic [3:0] ST_KRD  = 4'd2;
    localparam logic [3:0] ST_KACC = 4'd3;
    localparam logic [3:0] ST_KW1  = 4'd4;
    localparam logic [3:0] ST_KW2  = 4'd5;
    localparam logic [3:0] ST_ACK  = 4'd6;
    localparam logic [3:0] ST_CA   = 4'd7;
    localparam logic [3:0] ST_CB   = 4'd8;
    localparam logic [3:0] ST_CC   = 4'd9;

    logic [3:0]    state_reg, state_next;
    byte_t         n_reg, n_next;
    byte_t         acc_reg, acc_next;
    logic [KW-1:0] kpos_reg, kpos_next;
    byte_t         ptr_i_reg, ptr_i_next;
    byte_t         ptr_j_reg, ptr_j_next;
    klen_t         key_length_reg, key_length_next;
    logic          out_valid_reg, out_valid_next;

    byte_t         held_reg, held_next;
    byte_t         a_reg, a_next;
    byte_t         b_reg, b_next;
    byte_t         data_reg, data_next;
    byte_t         out_byte_reg, out_byte_next;
    logic          is_ack_reg, is_ack_next;

    logic          p_we;
    byte_t         p_waddr, p_wdata, p_raddr, p_rdata;
    logic          k_we;
    logic [KW-1:0] k_waddr;
    byte_t         k_rdata;

    logic          in_fire;
    logic          out_free;
    klen_t         len_eff;
    logic          kpos_wrap;
    logic          key_in_range;
    byte_t         ks_idx;
    byte_t         ks_byte;
    byte_t         acc_sum;

    rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    rc4_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_BYTES)) u_key (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (value),
        .raddr (kpos_reg),
        .rdata (k_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_ack    = is_ack_reg;

    assign key_in_range = ({1'b0, key_index} < KLEN_MAX);
    assign k_waddr      = key_index[KW-1:0];
    assign k_we         = in_fire && (mode == MODE_KEY) && key_in_range;

    assign kpos_wrap = ((KLEN_W'(kpos_reg) + 9'd1) >= len_eff);
    assign acc_sum   = acc_reg + p_rdata + k_rdata;
    assign ks_idx    = a_reg + b_reg;

    always_comb
    begin
        priority if (key_length_reg == '0)
        begin
            len_eff = 9'd1;
        end
        else if (key_length_reg > KLEN_MAX)
        begin
            len_eff = KLEN_MAX;
        end
        else
        begin
            len_eff = key_length_reg;
        end
    end

    // keystream byte as seen after the swap
    always_comb
    begin
        priority if (ks_idx == ptr_j_reg)
        begin
            ks_byte = a_reg;
        end
        else if (ks_idx == ptr_i_reg)
        begin
            ks_byte = b_reg;
        end
        else
        begin
            ks_byte = p_rdata;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        acc_next        = acc_reg;
        kpos_next       = kpos_reg;
        ptr_i_next      = ptr_i_reg;
        ptr_j_next      = ptr_j_reg;
        key_length_next = key_length_reg;
        out_valid_next  = out_valid_reg && out_stall;
        held_next       = held_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        data_next       = data_reg;
        out_byte_next   = out_byte_reg;
        is_ack_next     = is_ack_reg;
        p_we            = 1'b0;
        p_waddr         = n_reg;
        p_wdata         = n_reg;
        p_raddr         = ptr_i_reg + 8'd1;

        if (cfg_valid && cfg_ready)
        begin
            key_length_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (mode)
                        MODE_SETUP:
                        begin
                            n_next     = '0;
                            acc_next   = '0;
                            kpos_next  = '0;
                            ptr_i_next = '0;
                            ptr_j_next = '0;
                            state_next = ST_FILL;
                        end
                        MODE_CRYPT:
                        begin
                            ptr_i_next = ptr_i_reg + 8'd1;
                            data_next  = value;
                            state_next = ST_CA;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                p_we   = 1'b1;
                n_next = n_reg + 8'd1;
                if (n_reg == PERM_LAST)
                begin
                    state_next = ST_KRD;
                end
            end
            ST_KRD:
            begin
                p_raddr    = n_reg;
                state_next = ST_KACC;
            end
            ST_KACC:
            begin
                held_next  = p_rdata;
                acc_next   = acc_sum;
                p_raddr    = acc_sum;
                state_next = ST_KW1;
            end
            ST_KW1:
            begin
                p_we       = 1'b1;
                p_waddr    = n_reg;
                p_wdata    = p_rdata;
                state_next = ST_KW2;
            end
            ST_KW2:
            begin
                p_we      = 1'b1;
                p_waddr   = acc_reg;
                p_wdata   = held_reg;
                n_next    = n_reg + 8'd1;
                kpos_next = kpos_wrap ? '0 : kpos_reg + KW'(1);
                state_next = (n_reg == PERM_LAST) ? ST_ACK : ST_KRD;
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    is_ack_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CA:
            begin
                a_next     = p_rdata;
                ptr_j_next = ptr_j_reg + p_rdata;
                p_raddr    = ptr_j_reg + p_rdata;
                state_next = ST_CB;
            end
            ST_CB:
            begin
                b_next     = p_rdata;
                p_we       = 1'b1;
                p_waddr    = ptr_i_reg;
                p_wdata    = p_rdata;
                p_raddr    = a_reg + p_rdata;
                state_next = ST_CC;
            end
            ST_CC:
            begin
                p_we    = 1'b1;
                p_waddr = ptr_j_reg;
                p_wdata = a_reg;
                p_raddr = ks_idx;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ ks_byte;
                    is_ack_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            n_reg          <= '0;
            acc_reg        <= '0;
            kpos_reg       <= '0;
            ptr_i_reg      <= '0;
            ptr_j_reg      <= '0;
            key_length_reg <= KLEN_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            acc_reg        <= acc_next;
            kpos_reg       <= kpos_next;
            ptr_i_reg      <= ptr_i_next;
            ptr_j_reg      <= ptr_j_next;
            key_length_reg <= key_length_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg     <= held_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        data_reg     <= data_next;
        out_byte_reg <= out_byte_next;
        is_ack_reg   <= is_ack_next;
    end

endmodule : rc4_keystream_cipher
`default_nettype wire

// ===== hdl/rc4_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rc4_checker
// Port-level checks of the RC4 keystream cipher, bound to the top level.
// ----------------------------------------------------------------------------
module rc4_checker
    import rc4_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [1:0] mode,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       is_ack
);

    logic in_fire;

    assign in_fire = in_valid && !in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_ack))
        else $error("output beat changed while stalled");

    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_ack |-> out_byte == 8'd0)
        else $error("setup ack carries nonzero byte");

    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (mode == MODE_SETUP || mode == MODE_CRYPT) |=> in_stall)
        else $error("input not stalled while a beat is in work");

    a_key_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && mode == MODE_KEY |=> !in_stall)
        else $error("key load did not complete in one cycle");

endmodule : rc4_checker

bind rc4_keystream_cipher rc4_checker u_rc4_checker (.*);
`default_nettype wire
